// ===== hw/rtl/svd_product_term_index_sequencer_macros.svh =====
// Assertion macros used by the checker file.
`ifndef SVD_PRODUCT_TERM_INDEX_SEQUENCER_MACROS_SVH
`define SVD_PRODUCT_TERM_INDEX_SEQUENCER_MACROS_SVH

// expr must never hold outside reset
`define SVD_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed");

// cons must hold in the cycle after ante
`define SVD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// cons must hold in the same cycle as ante
`define SVD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/svd_pti_pkg.sv =====
package svd_pti_pkg;

   localparam int CFG_W = 7;
   localparam int IDX_W = 12;
   localparam int PH_W  = 3;
   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] REG_ROWS_N  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_INNER_M = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_COLS_R  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_RANK_A  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_RANK_B  = 3'd4;

   localparam logic [PH_W-1:0] PH_SCALE_A  = 3'd0;
   localparam logic [PH_W-1:0] PH_PROD_A   = 3'd1;
   localparam logic [PH_W-1:0] PH_SCALE_B  = 3'd2;
   localparam logic [PH_W-1:0] PH_PROD_MID = 3'd3;
   localparam logic [PH_W-1:0] PH_PROD_OUT = 3'd4;
   localparam logic [PH_W-1:0] PH_DONE     = 3'd5;

   typedef struct packed {
      logic start;
      logic load;
      logic step;
   } cmd_type;

   typedef struct packed {
      logic live;
      logic last;
   } sts_type;

endpackage

// ===== hw/rtl/svd_pti_ctrl.sv =====
module svd_pti_ctrl
   import svd_pti_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CALC = 2'd1;
   localparam logic [1:0] S_EMIT = 2'd2;

   logic [1:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_EMIT);

   always_comb begin
      state_in  = state_ff;
      cmd.start = 1'b0;
      cmd.load  = 1'b0;
      cmd.step  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && sts.live) begin
               cmd.start = 1'b1;
               state_in  = S_CALC;
            end
         end
         S_CALC: begin
            cmd.load = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (rsp_ready) begin
               if (sts.last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.step = 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/svd_pti_datapath.sv =====
module svd_pti_datapath
   import svd_pti_pkg::*;
#(
   parameter int MAX_DIM = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_data,
   input  logic                   request,
   input  cmd_type                cmd,
   output sts_type                sts,
   output logic [PH_W-1:0]        rsp_phase,
   output logic [IDX_W-1:0]       rsp_left_index,
   output logic [IDX_W-1:0]       rsp_right_index,
   output logic                   rsp_last_term,
   output logic                   rsp_phase_end
);

   localparam int CW      = $clog2(MAX_DIM);
   localparam int DIM_CAP = (MAX_DIM > 127) ? 127 : MAX_DIM;
   localparam logic [CFG_W-1:0] CAP = CFG_W'(DIM_CAP);
   localparam int CMP_W   = 9;

   function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
      logic [CFG_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = CFG_W'(1);
      end else if (v > CAP) begin
         r = CAP;
      end
      return r;
   endfunction

   logic [CFG_W-1:0] rows_n_ff, inner_m_ff, cols_r_ff, rank_a_ff, rank_b_ff;
   logic [CW-1:0]    row_ff, row_in, col_ff, col_in;
   logic [PH_W-1:0]  phase_ff, phase_in;
   logic [CW-1:0]    cur_i_ff, cur_j_ff;
   logic [PH_W-1:0]  cur_ph_ff;
   logic             pend_ff;
   logic [IDX_W-1:0] left_ff, left_in, right_ff, right_in;
   logic [CFG_W-1:0] k_ff, k_in;

   logic [CFG_W-1:0] n_e, m_e, r_e, s1_e, s2_e, mn_e, mx_e;
   logic [CFG_W-1:0] jb, ib, mult_a, rstep, last_k;
   logic [CW:0]      nj_w, ni_w;
   logic             wrap_j, wrap_i;
   logic [IDX_W-1:0] prod;

   always_comb begin
      n_e  = clamp_dim(rows_n_ff);
      m_e  = clamp_dim(inner_m_ff);
      r_e  = clamp_dim(cols_r_ff);
      s1_e = clamp_dim(rank_a_ff);
      s2_e = clamp_dim(rank_b_ff);
      mn_e = (s1_e < s2_e) ? s1_e : s2_e;
      mx_e = (s1_e < s2_e) ? s2_e : s1_e;
   end

   always_comb begin
      case (phase_ff)
         PH_SCALE_A:  begin jb = s1_e; ib = n_e;  end
         PH_PROD_A:   begin jb = s2_e; ib = s1_e; end
         PH_SCALE_B:  begin jb = s2_e; ib = r_e;  end
         PH_PROD_MID: begin jb = r_e;  ib = mx_e; end
         default:     begin jb = r_e;  ib = n_e;  end
      endcase
      nj_w   = {1'b0, col_ff} + (CW+1)'(1);
      wrap_j = (CMP_W'(nj_w) >= CMP_W'(jb));
      ni_w   = wrap_j ? ({1'b0, row_ff} + (CW+1)'(1)) : {1'b0, row_ff};
      wrap_i = (CMP_W'(ni_w) >= CMP_W'(ib));
      col_in   = wrap_j ? '0 : CW'(nj_w);
      row_in   = wrap_i ? '0 : CW'(ni_w);
      phase_in = wrap_i ? (phase_ff + PH_W'(1)) : phase_ff;
   end

   always_comb begin
      case (cur_ph_ff)
         PH_SCALE_A:  begin mult_a = s1_e; rstep = '0;   last_k = '0;                end
         PH_PROD_A:   begin mult_a = m_e;  rstep = s2_e; last_k = m_e - CFG_W'(1);   end
         PH_SCALE_B:  begin mult_a = s2_e; rstep = '0;   last_k = '0;                end
         PH_PROD_MID: begin mult_a = mn_e; rstep = r_e;  last_k = mn_e - CFG_W'(1);  end
         default:     begin mult_a = s1_e; rstep = r_e;  last_k = s1_e - CFG_W'(1);  end
      endcase
      prod = IDX_W'(cur_i_ff) * IDX_W'(mult_a);
   end

   always_comb begin
      left_in  = left_ff;
      right_in = right_ff;
      k_in     = k_ff;
      if (cmd.load) begin
         k_in = '0;
         if (cur_ph_ff == PH_SCALE_B) begin
            left_in  = IDX_W'(cur_j_ff);
            right_in = prod + IDX_W'(cur_j_ff);
         end else begin
            left_in  = (cur_ph_ff == PH_SCALE_A) ? (prod + IDX_W'(cur_j_ff)) : prod;
            right_in = IDX_W'(cur_j_ff);
         end
      end else if (cmd.step) begin
         left_in  = left_ff + IDX_W'(1);
         right_in = right_ff + IDX_W'(rstep);
         k_in     = k_ff + CFG_W'(1);
      end
   end

   assign sts.live = request && (phase_ff < PH_DONE);
   assign sts.last = (k_ff == last_k);

   assign rsp_phase       = cur_ph_ff;
   assign rsp_left_index  = left_ff;
   assign rsp_right_index = right_ff;
   assign rsp_last_term   = sts.last;
   assign rsp_phase_end   = pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_n_ff  <= CFG_W'(1);
         inner_m_ff <= CFG_W'(1);
         cols_r_ff  <= CFG_W'(1);
         rank_a_ff  <= CFG_W'(1);
         rank_b_ff  <= CFG_W'(1);
         row_ff     <= '0;
         col_ff     <= '0;
         phase_ff   <= PH_SCALE_A;
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_ROWS_N:  rows_n_ff  <= csr_data;
               REG_INNER_M: inner_m_ff <= csr_data;
               REG_COLS_R:  cols_r_ff  <= csr_data;
               REG_RANK_A:  rank_a_ff  <= csr_data;
               REG_RANK_B:  rank_b_ff  <= csr_data;
               default: ;
            endcase
         end
         if (cmd.start) begin
            row_ff   <= row_in;
            col_ff   <= col_in;
            phase_ff <= phase_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         cur_i_ff  <= row_ff;
         cur_j_ff  <= col_ff;
         cur_ph_ff <= phase_ff;
         pend_ff   <= wrap_i && (phase_ff != PH_PROD_OUT);
      end
      left_ff  <= left_in;
      right_ff <= right_in;
      k_ff     <= k_in;
   end

endmodule

// ===== hw/rtl/svd_product_term_index_sequencer.sv =====
// channel   ports            tdata (low bit up)             tuser / tlast
// request   req_t*           request, 7 unused bits         -
// response  rsp_t*           left_index, right_index        phase, phase_end / last_term
// config    csr_*            csr_index selects, csr_data    -
//
// A live request is accepted in S_IDLE and the row product is set up in S_CALC,
// then one term is given per cycle while rsp_tready is high: 1, inner_m,
// min(rank_a, rank_b) or rank_a terms, up to MAX_DIM.
// Synchronous reset clears the iterator and sets every config register to 1.
// rsp_tready low holds the current term; no request is taken until the last
// term of the element leaves.
module svd_product_term_index_sequencer
   import svd_pti_pkg::*;
#(
   parameter int MAX_DIM = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // request
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [23:0]            rsp_tdata,   // left_index, right_index
   output logic [3:0]             rsp_tuser,   // phase, phase_end
   output logic                   rsp_tlast,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_data
);

   cmd_type          cmd;
   sts_type          sts;
   logic [PH_W-1:0]  phase;
   logic [IDX_W-1:0] left_index, right_index;
   logic             last_term, phase_end;

   assign csr_ready = 1'b1;

   svd_pti_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   svd_pti_datapath #(
      .MAX_DIM (MAX_DIM)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .request         (req_tdata[0]),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_phase       (phase),
      .rsp_left_index  (left_index),
      .rsp_right_index (right_index),
      .rsp_last_term   (last_term),
      .rsp_phase_end   (phase_end)
   );

   assign rsp_tdata = {right_index, left_index};
   assign rsp_tuser = {phase_end, phase};
   assign rsp_tlast = last_term;

endmodule

// ===== hw/rtl/svd_pti_checker.sv =====
`include "svd_product_term_index_sequencer_macros.svh"

module svd_pti_checker
   import svd_pti_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [3:0]  rsp_tuser,
   input logic        rsp_tlast
);

   `SVD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   `SVD_ASSERT_NEVER(a_one_at_a_time, clock, reset, req_tready && rsp_tvalid)
   `SVD_ASSERT_SAME(a_phase_range, clock, reset, rsp_tvalid, (rsp_tuser[2:0] < PH_PROD_OUT) || (rsp_tuser[2:0] == PH_PROD_OUT && !rsp_tuser[3]))
   `SVD_ASSERT_NEXT(a_idle_after_last, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast, req_tready && !rsp_tvalid)

endmodule

bind svd_product_term_index_sequencer svd_pti_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
